/* hw/rtl/hfc_pkg.sv */
// ----------------------------------------------------------------------------
// hfc_pkg
// Shared types and constants for the half/single float converter.
// ----------------------------------------------------------------------------
package hfc_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic {
    FUNC_S2H = 1'b0,
    FUNC_H2S = 1'b1
  } func_t;

  localparam logic [7:0]  ExpTiny     = 8'd103;
  localparam logic [7:0]  ExpHuge     = 8'd142;
  localparam logic [7:0]  ExpDenMax   = 8'd112;
  localparam logic [7:0]  ExpSpecial  = 8'd255;
  localparam logic [31:0] QuietNan32  = 32'h7FC0_0000;
  localparam logic [31:0] Inf32       = 32'h7F80_0000;
  localparam logic [14:0] Inf16       = 15'h7C00;

endpackage

/* hw/rtl/half_float_converter.sv */
// ----------------------------------------------------------------------------
// half_float_converter
// Converts single to half or half to single bit patterns, one per cycle.
// ----------------------------------------------------------------------------
// A transaction is taken whenever start is high; busy is always low. The
// result appears on converted with done high for one cycle. Three register
// stages (decode, shift and round, pack) let a new transaction enter every
// cycle; the receiver cannot stall the pipeline.
module half_float_converter (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     func,
  input  logic [hfc_pkg::DataW-1:0] operand,
  output logic                     done,
  output logic [hfc_pkg::DataW-1:0] converted
);
  import hfc_pkg::*;

  // stage 1: decode
  logic        v1;
  logic        f1;
  logic        s1;
  logic [7:0]  e1;
  logic [22:0] m1;
  logic [3:0]  sh1;     // denormal shift amount (114 - e), 2..11
  logic [3:0]  lz1;     // half denormal msb position
  logic [1:0]  cls1;    // class code

  localparam logic [1:0] ClsZero = 2'd0;
  localparam logic [1:0] ClsSpec = 2'd1;
  localparam logic [1:0] ClsDen  = 2'd2;
  localparam logic [1:0] ClsNorm = 2'd3;

  logic [1:0]  cls_next;
  logic [3:0]  lz_next;
  logic [7:0]  sh_full;

  always_comb begin
    lz_next = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (operand[i]) lz_next = 4'(i);
    end
    sh_full = 8'd114 - operand[30:23];
    if (func == FUNC_S2H) begin
      if (operand[30:23] < ExpTiny) cls_next = ClsZero;
      else if (operand[30:23] > ExpHuge) cls_next = ClsSpec;
      else if (operand[30:23] <= ExpDenMax) cls_next = ClsDen;
      else cls_next = ClsNorm;
    end else begin
      if (operand[14:10] == 5'h1F) cls_next = ClsSpec;
      else if (operand[14:10] != 5'd0) cls_next = ClsNorm;
      else if (operand[9:0] == 10'd0) cls_next = ClsZero;
      else cls_next = ClsDen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    f1   <= func;
    s1   <= (func == FUNC_S2H) ? operand[31] : operand[15];
    e1   <= (func == FUNC_S2H) ? operand[30:23] : {3'd0, operand[14:10]};
    m1   <= (func == FUNC_S2H) ? operand[22:0] : {13'd0, operand[9:0]};
    sh1  <= sh_full[3:0];
    lz1  <= lz_next;
    cls1 <= cls_next;
  end

  // stage 2: shift and round
  logic        v2;
  logic        f2;
  logic        s2;
  logic [1:0]  cls2;
  logic [14:0] h2;      // magnitude before rounding increment
  logic        r2;      // rounding increment
  logic [30:0] w2;      // single magnitude
  logic        nan2;

  logic [11:0] big;
  logic [11:0] den_q;
  logic [11:0] den_r;
  logic [22:0] hm_sh;
  logic [14:0] h2_next;
  logic        r2_next;
  logic [30:0] w2_next;
  logic        nan_next;

  always_comb begin
    big   = {1'b1, m1[22:12]};
    den_q = big >> sh1;
    den_r = big >> (sh1 - 4'd1);
    hm_sh = m1 << (5'd23 - {1'b0, lz1});
    h2_next = 15'd0;
    r2_next = 1'b0;
    w2_next = 31'd0;
    // for single to half, nan only when exponent is all ones
    nan_next = (f1 == FUNC_S2H) ? ((e1 == ExpSpecial) && (m1 != 23'd0)) : (m1 != 23'd0);
    if (f1 == FUNC_S2H) begin
      case (cls1)
        ClsDen: begin
          h2_next = {3'd0, den_q};
          r2_next = den_r[0];
        end
        ClsNorm: begin
          h2_next = {5'(e1 - ExpDenMax), m1[22:13]};
          r2_next = m1[12];
        end
        default: begin
          h2_next = 15'd0;
        end
      endcase
    end else begin
      case (cls1)
        ClsNorm: w2_next = {8'(e1 + 8'd112), m1[9:0], 13'd0};
        ClsDen:  w2_next = {8'({4'd0, lz1} + 8'd103), hm_sh};
        default: w2_next = 31'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    f2   <= f1;
    s2   <= s1;
    cls2 <= cls1;
    nan2 <= nan_next;
    h2   <= h2_next;
    r2   <= r2_next;
    w2   <= w2_next;
  end

  // stage 3: pack
  logic        v3;
  logic        f3q;
  logic [31:0] res3;
  logic [31:0] res_next;
  logic [14:0] hsum;

  always_comb begin
    hsum = h2 + {14'd0, r2};
    if (f2 == FUNC_S2H) begin
      case (cls2)
        ClsZero: res_next = {16'd0, s2, 15'd0};
        ClsSpec: res_next = {16'd0, s2, Inf16[14:1], nan2};
        default: res_next = {16'd0, s2, hsum};
      endcase
    end else begin
      case (cls2)
        ClsZero: res_next = {s2, 31'd0};
        ClsSpec: res_next = nan2 ? QuietNan32 : {s2, Inf32[30:0]};
        default: res_next = {s2, w2};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    f3q  <= f2;
    res3 <= res_next;
  end

  assign busy      = 1'b0;
  assign done      = v3;
  assign converted = res3;

`ifndef NO_ASSERTIONS
  a_lat: assert property (@(posedge clk) disable iff (rst)
    start |=> ##2 done) else $error("done missing three cycles after start");
  a_nostray: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 3)) else $error("done without a transaction");
  a_hi_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !f3q) |-> (converted[31:16] == 16'd0))
    else $error("half result has upper bits set");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the half/single float converter against a built-in predictor of both
// conversion directions, with bursty random stimulus and directed corner cases.
// ----------------------------------------------------------------------------
module tb_top;
  import hfc_pkg::*;

  typedef struct packed {
    func_t       func;
    logic [31:0] operand;
  } conv_req_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        func;
  logic [31:0] operand;
  logic        done;
  logic [31:0] converted;

  conv_req_t   pending_q[$];
  logic [31:0] expected_q[$];
  int          errors;
  bit          stim_done;
  int          burst_left;
  int          gap_left;
  // busy as seen at the last rising edge
  logic        busy_q;

  half_float_converter u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .operand(operand), .done(done), .converted(converted)
  );

  function automatic logic [31:0] to_half(logic [31:0] x);
    logic [15:0] sgn;
    logic [10:0] g;
    logic [7:0]  e;
    logic [11:0] big;
    logic [15:0] h;
    sgn = {x[31], 15'd0};
    g = x[22:12];
    e = x[30:23];
    if (e < 8'd103) return {16'd0, sgn};
    if (e > 8'd142) begin
      h = sgn | 16'h7C00;
      if (e == 8'd255 && x[22:0] != 23'd0) h[0] = 1'b1;
      return {16'd0, h};
    end
    if (e < 8'd113) begin
      big = {1'b1, g};
      h = sgn | 16'((big >> (8'd114 - e)) + ((big >> (8'd113 - e)) & 12'd1));
      return {16'd0, h};
    end
    h = sgn | {1'b0, 5'(e - 8'd112), g[10:1]};
    h = h + {15'd0, g[0]};
    return {16'd0, h};
  endfunction

  function automatic logic [31:0] to_single(logic [31:0] x);
    logic [31:0] sgn;
    logic [4:0]  e;
    logic [9:0]  m;
    int          p;
    sgn = {x[15], 31'd0};
    e = x[14:10];
    m = x[9:0];
    if (e == 5'h1F) return (m != 0) ? 32'h7FC0_0000 : (sgn | 32'h7F80_0000);
    if (e != 0) return sgn | {1'b0, 8'(e + 8'd112), m, 13'd0};
    if (m == 0) return sgn;
    p = 9;
    while (m[p] == 1'b0) p--;
    return sgn | (32'(p + 103) << 23) | ((32'(m) << (23 - p)) & 32'h007F_FFFF);
  endfunction

  function automatic logic [31:0] convert_expected(conv_req_t r);
    return (r.func == FUNC_S2H) ? to_half(r.operand) : to_single(r.operand);
  endfunction

  // random single with exponent mostly in the interesting band
  function automatic logic [31:0] rand_single();
    logic [7:0] e;
    case ($urandom_range(0, 5))
      0: e = 8'($urandom);
      1: e = 8'($urandom_range(100, 115));
      2: e = 8'($urandom_range(140, 143));
      3: e = 8'd255;
      default: e = 8'($urandom_range(103, 142));
    endcase
    return {1'($urandom), e, 23'($urandom)};
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    logic [31:0] dir_s[] = '{32'h0000_0000, 32'h8000_0000, 32'h3300_0000, 32'h337F_FFFF,
                             32'h3380_0000, 32'h387F_F000, 32'h387F_E000, 32'h3800_0000,
                             32'h477F_E000, 32'h477F_F000, 32'h4780_0000, 32'h7F80_0000,
                             32'hFF80_0001, 32'h7FFF_FFFF, 32'hC000_0000};
    logic [31:0] dir_h[] = '{32'h0000_0000, 32'h0000_8000, 32'h0000_0001, 32'hFFFF_83FF,
                             32'h0000_0200, 32'h0000_0400, 32'h0000_7BFF, 32'h0000_7C00,
                             32'hABCD_FC00, 32'h0000_7C01, 32'h0000_FFFF};
    conv_req_t r;
    foreach (dir_s[i]) begin
      r.func = FUNC_S2H; r.operand = dir_s[i]; pending_q.push_back(r);
    end
    foreach (dir_h[i]) begin
      r.func = FUNC_H2S; r.operand = dir_h[i]; pending_q.push_back(r);
    end
    for (int i = 0; i < 1750; i++) begin
      if ($urandom_range(0, 1)) begin
        r.func = FUNC_S2H;
        r.operand = ($urandom_range(0, 9) == 0) ? $urandom : rand_single();
      end else begin
        r.func = FUNC_H2S;
        r.operand = $urandom;
      end
      pending_q.push_back(r);
    end
  end

  // driver: bursts with random gaps
  initial begin
    rst = 1'b1;
    start = 1'b0;
    func = 1'b0;
    operand = '0;
    burst_left = 0;
    gap_left = 0;
    errors = 0;
    stim_done = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  always @(negedge clk) begin
    if (!rst) begin
      // drop the transaction taken at the last rising edge
      if (start && !busy_q) void'(pending_q.pop_front());
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_q.size() == 0) begin
        start <= 1'b0;
        stim_done <= 1'b1;
      end else begin
        start <= 1'b1;
        func <= pending_q[0].func;
        operand <= pending_q[0].operand;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    busy_q <= busy;
    if (!rst && start && !busy) begin
      expected_q.push_back(convert_expected(conv_req_t'{func_t'(func), operand}));
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $error("unexpected transaction: converted=%h", converted);
        errors++;
      end else begin
        if (converted !== expected_q[0]) begin
          $error("converted: expected %h actual %h", expected_q[0], converted);
          errors++;
        end
        void'(expected_q.pop_front());
      end
    end
  end

  initial begin
    wait (stim_done);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
